// ===== hw/rtl/ihex_pkg.sv =====
// Shared types, constants and the hex digit decoder for the HEX record loader.
// No dependencies; every other file of the block imports this package.
package ihex_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned AddrW   = 18;
  localparam int unsigned SegW    = 20;
  localparam int unsigned OffW    = 16;
  localparam int unsigned AbsW    = 21;
  localparam int unsigned StatusW = 3;

  localparam int unsigned DefImageBytes = 262144;

  // Result status codes
  localparam logic [StatusW-1:0] ST_OK         = 3'd0;
  localparam logic [StatusW-1:0] ST_NO_COLON   = 3'd1;
  localparam logic [StatusW-1:0] ST_TOO_LARGE  = 3'd2;
  localparam logic [StatusW-1:0] ST_BAD_SEGLEN = 3'd3;
  localparam logic [StatusW-1:0] ST_SHORT      = 3'd4;
  localparam logic [StatusW-1:0] ST_HALTED     = 3'd5;

  // Characters of interest
  localparam logic [CharW-1:0] CH_COLON   = 8'h3A;
  localparam logic [CharW-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CharW-1:0] CH_ZERO    = 8'h30;
  localparam logic [CharW-1:0] CH_NINE    = 8'h39;
  localparam logic [CharW-1:0] CH_UPPER_A = 8'h41;

  typedef struct packed {
    logic               write_valid;
    logic [AddrW-1:0]   write_addr;
    logic [7:0]         write_data;
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   highest_addr;
  } ihex_result_t;

  // Digits up to '9' count from '0', everything else from 'A' minus ten;
  // keep the low nibble, so lowercase letters decode as well.
  function automatic logic [3:0] hex_nibble(input logic [CharW-1:0] c);
    logic [CharW-1:0] v;
    if (c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else begin
      v = c + 8'd10 - CH_UPPER_A;
    end
    return v[3:0];
  endfunction

endpackage

// ===== hw/rtl/ihex_in_reg.sv =====
// Input register stage of the HEX record loader: holds one character item.
// Depends on ihex_pkg.
module ihex_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ihex_pkg::CharW-1:0] char_code_i,
  input  logic                       advance_i,
  output logic                       step_o,
  output logic [ihex_pkg::CharW-1:0] char_o
);
  import ihex_pkg::*;

  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic             load;

  // The stage takes a new item when it is empty or moves on this cycle.
  assign load       = !valid_q || advance_i;
  assign in_stall_o = !load;
  assign step_o     = valid_q && advance_i;
  assign char_o     = char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      char_q <= char_code_i;
    end
  end

endmodule

// ===== hw/rtl/ihex_parser.sv =====
// Record parser of the HEX record loader: parse state and one-character step.
// Depends on ihex_pkg.
module ihex_parser #(
  parameter int unsigned IMAGE_BYTES = ihex_pkg::DefImageBytes
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [ihex_pkg::CharW-1:0] char_i,
  output ihex_pkg::ihex_result_t     result_o
);
  import ihex_pkg::*;

  localparam logic [AbsW-1:0] ImageLimit = AbsW'(IMAGE_BYTES);

  localparam logic [2:0] PH_LINE_START = 3'd0;
  localparam logic [2:0] PH_LENGTH     = 3'd1;
  localparam logic [2:0] PH_OFFSET     = 3'd2;
  localparam logic [2:0] PH_KIND       = 3'd3;
  localparam logic [2:0] PH_DATA       = 3'd4;
  localparam logic [2:0] PH_SEGMENT    = 3'd5;
  localparam logic [2:0] PH_TAIL       = 3'd6;

  logic [2:0]      phase_q, phase_d;
  logic [3:0]      digit_count_q, digit_count_d;
  logic [7:0]      bytes_left_q, bytes_left_d;
  logic [7:0]      record_length_q, record_length_d;
  logic [OffW-1:0] record_offset_q, record_offset_d;
  logic [7:0]      record_kind_q, record_kind_d;
  logic [15:0]     digit_accum_q, digit_accum_d;
  logic [SegW-1:0] segment_base_q, segment_base_d;
  logic [AddrW-1:0] highest_q, highest_d;
  logic            halted_q, halted_d;

  logic [15:0]     accum_new;
  logic [3:0]      count_new;
  logic [3:0]      need;
  logic [AbsW-1:0] abs_addr;
  logic [7:0]      bytes_left_new;
  ihex_result_t    res;

  always_comb begin
    phase_d         = phase_q;
    digit_count_d   = digit_count_q;
    bytes_left_d    = bytes_left_q;
    record_length_d = record_length_q;
    record_offset_d = record_offset_q;
    record_kind_d   = record_kind_q;
    digit_accum_d   = digit_accum_q;
    segment_base_d  = segment_base_q;
    highest_d       = highest_q;
    halted_d        = halted_q;
    res             = '0;
    res.status      = ST_OK;

    accum_new      = {digit_accum_q[11:0], hex_nibble(char_i)};
    count_new      = digit_count_q + 4'd1;
    need           = (phase_q == PH_OFFSET || phase_q == PH_SEGMENT) ? 4'd4 : 4'd2;
    abs_addr       = AbsW'(segment_base_q) + AbsW'(record_offset_q);
    bytes_left_new = bytes_left_q - 8'd1;

    if (step_i) begin
      if (halted_q) begin
        res.status = ST_HALTED;
      end else if (phase_q == PH_LINE_START) begin
        if (char_i == CH_COLON) begin
          phase_d       = PH_LENGTH;
          digit_count_d = '0;
          digit_accum_d = '0;
        end else begin
          res.status = ST_NO_COLON;
          halted_d   = 1'b1;
        end
      end else if (phase_q >= PH_TAIL) begin
        if (char_i == CH_NEWLINE) begin
          phase_d       = PH_LINE_START;
          digit_count_d = '0;
          digit_accum_d = '0;
        end
      end else if (char_i == CH_NEWLINE) begin
        res.status = ST_SHORT;
        halted_d   = 1'b1;
      end else begin
        digit_accum_d = accum_new;
        digit_count_d = count_new;
        if (count_new >= need) begin
          // Field complete: clear the digit collector unless an error halts.
          digit_count_d = '0;
          digit_accum_d = '0;
          case (phase_q)
            PH_LENGTH: begin
              record_length_d = accum_new[7:0];
              phase_d         = PH_OFFSET;
            end
            PH_OFFSET: begin
              record_offset_d = accum_new;
              phase_d         = PH_KIND;
            end
            PH_KIND: begin
              record_kind_d = accum_new[7:0];
              if (accum_new[7:0] == 8'd0) begin
                bytes_left_d = record_length_q;
                phase_d      = (record_length_q == 8'd0) ? PH_TAIL : PH_DATA;
              end else if (accum_new[7:0] == 8'd2) begin
                if (record_length_q != 8'd2) begin
                  res.status    = ST_BAD_SEGLEN;
                  halted_d      = 1'b1;
                  digit_accum_d = accum_new;
                  digit_count_d = count_new;
                end else begin
                  phase_d = PH_SEGMENT;
                end
              end else begin
                phase_d = PH_TAIL;
              end
            end
            PH_DATA: begin
              if (abs_addr >= ImageLimit) begin
                res.status    = ST_TOO_LARGE;
                halted_d      = 1'b1;
                digit_accum_d = accum_new;
                digit_count_d = count_new;
              end else begin
                res.write_valid = 1'b1;
                res.write_addr  = abs_addr[AddrW-1:0];
                res.write_data  = accum_new[7:0];
                if (abs_addr[AddrW-1:0] > highest_q) begin
                  highest_d = abs_addr[AddrW-1:0];
                end
                record_offset_d = record_offset_q + 16'd1;
                bytes_left_d    = bytes_left_new;
                phase_d         = (bytes_left_new == 8'd0) ? PH_TAIL : PH_DATA;
              end
            end
            default: begin
              segment_base_d = {accum_new, 4'h0};
              phase_d        = PH_TAIL;
            end
          endcase
        end
      end
    end
    res.highest_addr = highest_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_LINE_START;
      digit_count_q   <= '0;
      bytes_left_q    <= '0;
      record_length_q <= '0;
      record_offset_q <= '0;
      record_kind_q   <= '0;
      digit_accum_q   <= '0;
      segment_base_q  <= '0;
      highest_q       <= '0;
      halted_q        <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      digit_count_q   <= digit_count_d;
      bytes_left_q    <= bytes_left_d;
      record_length_q <= record_length_d;
      record_offset_q <= record_offset_d;
      record_kind_q   <= record_kind_d;
      digit_accum_q   <= digit_accum_d;
      segment_base_q  <= segment_base_d;
      highest_q       <= highest_d;
      halted_q        <= halted_d;
    end
  end

  // Halt is sticky until reset.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  // The high-water mark never moves down.
  a_highest_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> highest_q >= $past(highest_q))
    else $error("highest address decreased");

  // Once halted, every item reports halted and writes nothing.
  a_halted_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halted_q && step_i) |-> (res.status == ST_HALTED && !res.write_valid))
    else $error("halted parser produced a write or wrong status");

endmodule

// ===== hw/rtl/ihex_out_reg.sv =====
// Result register stage of the HEX record loader: holds one result item.
// Depends on ihex_pkg.
module ihex_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  ihex_pkg::ihex_result_t result_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ihex_pkg::ihex_result_t result_o
);
  import ihex_pkg::*;

  logic         valid_q;
  ihex_result_t result_q;

  // Move on when the register is empty or its item is taken now.
  assign advance_o   = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= step_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && step_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ===== hw/rtl/intel_hex_record_loader.sv =====
// Top level of the Intel HEX record loader: input register, parser, result register.
// Depends on ihex_pkg, ihex_in_reg, ihex_parser and ihex_out_reg.
//
// The loader takes Intel HEX text one ASCII character per item and returns one
// result item per character. Each line must open with ':' and then carry a
// two-digit byte count, a four-digit offset and a two-digit record type. Data
// records (type 0) produce one write per data byte at segment base plus the
// offset, the offset wrapping at 16 bits; the result flags the write, gives the
// 18-bit address and the byte, and always reports the highest address written
// so far. A segment record (type 2) must have a count of two and loads the
// segment base with its value shifted left by four. Other record types, the
// checksum and anything after the used fields up to the newline are ignored.
// Non-hex characters inside a field are not checked; they decode to some nibble.
// Errors: a line not starting with ':' (an empty line too), a data byte at or
// beyond IMAGE_BYTES (no write), a segment record with a wrong count, and a
// newline before the used fields are complete. The first error halts the
// loader; every later item reports "halted" until reset. One item per clock is
// sustained while the output side does not stall. The character passes through
// an input register, the parse step is combinational decode, add and compare
// against the parse state, and the result lands in an output register. Stall
// from the output side flows straight back to in_stall_o.
module intel_hex_record_loader #(
  parameter int unsigned IMAGE_BYTES = ihex_pkg::DefImageBytes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ihex_pkg::CharW-1:0]   char_code_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         write_valid_o,
  output logic [ihex_pkg::AddrW-1:0]   write_addr_o,
  output logic [7:0]                   write_data_o,
  output logic [ihex_pkg::StatusW-1:0] status_o,
  output logic [ihex_pkg::AddrW-1:0]   highest_addr_o
);
  import ihex_pkg::*;

  logic             advance;
  logic             step;
  logic [CharW-1:0] char_staged;
  ihex_result_t     parse_result;
  ihex_result_t     out_result;

  // Register the incoming character until the parse step takes it.
  ihex_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .advance_i   (advance),
    .step_o      (step),
    .char_o      (char_staged)
  );

  // Advance the parse state by one character.
  ihex_parser #(
    .IMAGE_BYTES (IMAGE_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .char_i   (char_staged),
    .result_o (parse_result)
  );

  // Hold the result until the consumer takes it.
  ihex_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .result_i    (parse_result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign write_valid_o  = out_result.write_valid;
  assign write_addr_o   = out_result.write_addr;
  assign write_data_o   = out_result.write_data;
  assign status_o       = out_result.status;
  assign highest_addr_o = out_result.highest_addr;

  // A write never lies above the reported high-water mark.
  a_write_below_highest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_valid_o) |-> (write_addr_o <= highest_addr_o))
    else $error("write address above highest address");

  // A write only comes with an ok status.
  a_write_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_valid_o) |-> (status_o == ST_OK))
    else $error("write reported with error status");

endmodule
